// ===== src/cyclic_timer_with_start_stop_override_defines.svh =====
// assertion macros for the cyclic timer block
// used by the top level only, no other dependencies
`ifndef CYCLIC_TIMER_WITH_START_STOP_OVERRIDE_DEFINES_SVH
`define CYCLIC_TIMER_WITH_START_STOP_OVERRIDE_DEFINES_SVH

// same-cycle implication
`define CTSO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CTSO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ctso_pkg.sv =====
// shared types and constants for the cyclic timer block
// no dependencies
`timescale 1ns / 1ps

package ctso_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CNT_W  = $clog2(WORD_W);

	// request kinds carried in tuser
	localparam logic [2:0] REQ_TICK       = 3'd0;
	localparam logic [2:0] REQ_START_DEF  = 3'd1;
	localparam logic [2:0] REQ_STOP_DEF   = 3'd2;
	localparam logic [2:0] REQ_START_EXPL = 3'd3;
	localparam logic [2:0] REQ_STOP_EXPL  = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_CYCLE_OFFSET  = 3'd0;
	localparam logic [2:0] CFG_ON_DURATION   = 3'd1;
	localparam logic [2:0] CFG_OFF_DURATION  = 3'd2;
	localparam logic [2:0] CFG_TIME_SCALE    = 3'd3;
	localparam logic [2:0] CFG_START_LENGTH  = 3'd4;
	localparam logic [2:0] CFG_STOP_LENGTH   = 3'd5;
	localparam logic [2:0] CFG_PORT_ENABLED  = 3'd6;
	localparam logic [2:0] CFG_INVERT_OUTPUT = 3'd7;

	// status of the serial remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== src/ctso_divider.sv =====
// serial restoring remainder unit, one quotient bit per cycle
// depends on ctso_pkg
`timescale 1ns / 1ps

module ctso_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ctso_pkg::WORD_W-1:0]  dividend,
	input  logic [ctso_pkg::WORD_W-1:0]  divisor,
	output logic [ctso_pkg::WORD_W-1:0]  remainder,
	output ctso_pkg::div_status_t        status
);

	logic [ctso_pkg::WORD_W-1:0] rem_q;
	logic [ctso_pkg::WORD_W-1:0] dvd_q;
	logic [ctso_pkg::WORD_W-1:0] dsr_q;
	logic [ctso_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [ctso_pkg::WORD_W:0]   trial;
	logic [ctso_pkg::WORD_W:0]   diff;

	// a zero divisor never borrows, so the dividend passes through unchanged
	assign trial = {rem_q, dvd_q[ctso_pkg::WORD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (!diff[ctso_pkg::WORD_W])
				rem_q <= diff[ctso_pkg::WORD_W-1:0];
			else
				rem_q <= trial[ctso_pkg::WORD_W-1:0];
		end
	end

	assign remainder   = rem_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ===== src/cyclic_timer_with_start_stop_override.sv =====
// cyclic on/off timer with one-shot start/stop override, top level
// depends on ctso_pkg, ctso_divider and the assertion macro header
//
// Each input word brings the time in seconds and a request (tick, start or
// stop). A tick evaluates the repeating on/off cycle: offset, on part and off
// part are scaled by time_scale through one shared 32x32 multiplier (three
// passes), the phase is reduced modulo the cycle length in a serial remainder
// unit that retires one bit per cycle, and an open start or stop window then
// overrides the result while port_enabled is set. A tick runs the 32 steps of
// the remainder unit; a tick with off_duration zero or negative skips the
// arithmetic. Start and stop requests take one multiply and one add; a
// repeated start or stop and an unknown request go straight to output. One
// word is processed at a time; s_axis_tready is high only while the sequencer
// is idle, which it is again from the cycle after the result is loaded. The
// result sits in an output register so the next word can be taken while the
// previous result still waits for m_axis_tready; a second result waits in the
// last sequencer step. All arithmetic is 32-bit and wraps; offset and off part
// are sign-extended, compares and remainder unsigned. The user must write
// configuration only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "cyclic_timer_with_start_stop_override_defines.svh"

module cyclic_timer_with_start_stop_override (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [31:0] now_seconds, [46:32] window_length, [47] zero
	input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [0] relay_on, [1] start_active, [2] stop_active
);

	// sequencer codes
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_MUL_O    = 4'd1;
	localparam logic [3:0] S_MUL_T    = 4'd2;
	localparam logic [3:0] S_MUL_F    = 4'd3;
	localparam logic [3:0] S_ADD      = 4'd4;
	localparam logic [3:0] S_DIV_GO   = 4'd5;
	localparam logic [3:0] S_DIV_WAIT = 4'd6;
	localparam logic [3:0] S_FIN      = 4'd7;
	localparam logic [3:0] S_REQ_MUL  = 4'd8;
	localparam logic [3:0] S_REQ_ADD  = 4'd9;
	localparam logic [3:0] S_OUT      = 4'd10;

	// configuration registers
	logic [15:0] cycle_offset_q;
	logic [14:0] on_duration_q;
	logic [15:0] off_duration_q;
	logic [31:0] time_scale_q;
	logic [14:0] start_length_q;
	logic [14:0] stop_length_q;
	logic        port_enabled_q;
	logic        invert_output_q;

	// timer state
	logic [31:0] deadline_q;
	logic        start_flag_q;
	logic        stop_flag_q;
	logic        relay_q;

	// sequencer and working registers
	logic [3:0]  state_q;
	logic        is_start_q;    // request is a start (else a stop)
	logic [31:0] now_q;
	logic [14:0] units_q;
	logic [31:0] o_q;           // scaled offset, later the dividend
	logic [31:0] t_q;           // scaled on part
	logic [31:0] f_q;           // scaled off part, later the cycle length
	logic        cyc_on_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  out_data_q;
	logic        out_load;

	// shared multiplier
	logic [31:0] mul_a;
	logic [31:0] prod;

	// remainder unit
	logic                  div_start;
	logic [31:0]           div_rem;
	ctso_pkg::div_status_t div_st;

	logic        off_nonpos;
	logic        in_fire;
	logic [2:0]  in_req;
	logic        fin_relay;
	logic        fin_clear;

	assign in_req     = s_axis_tuser;
	assign in_fire    = s_axis_tvalid && s_axis_tready;
	assign off_nonpos = off_duration_q[15] || (off_duration_q == '0);

	// result hand-over once the output register is free or draining
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

	// operand select for the one multiplier
	always_comb begin
		case (state_q)
			S_MUL_O: mul_a = {{16{cycle_offset_q[15]}}, cycle_offset_q};
			S_MUL_T: mul_a = {17'd0, on_duration_q};
			S_MUL_F: mul_a = {{16{off_duration_q[15]}}, off_duration_q};
			default: mul_a = {17'd0, units_q};
		endcase
	end

	assign prod = 32'(mul_a * time_scale_q);

	assign div_start = (state_q == S_DIV_GO);

	ctso_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (o_q),
		.divisor   (f_q),
		.remainder (div_rem),
		.status    (div_st)
	);

	// tick close-out: cycle result, then the window override
	always_comb begin
		fin_relay = cyc_on_q ^ invert_output_q;
		fin_clear = 1'b0;
		if (port_enabled_q) begin
			if (now_q < deadline_q) begin
				if (start_flag_q)
					fin_relay = 1'b1;
				if (stop_flag_q)
					fin_relay = 1'b0;
			end else begin
				fin_clear = 1'b1;
			end
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_offset_q  <= '0;
			on_duration_q   <= '0;
			off_duration_q  <= '0;
			time_scale_q    <= 32'd1;
			start_length_q  <= '0;
			stop_length_q   <= '0;
			port_enabled_q  <= 1'b1;
			invert_output_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctso_pkg::CFG_CYCLE_OFFSET:  cycle_offset_q  <= cfg_data[15:0];
				ctso_pkg::CFG_ON_DURATION:   on_duration_q   <= cfg_data[14:0];
				ctso_pkg::CFG_OFF_DURATION:  off_duration_q  <= cfg_data[15:0];
				ctso_pkg::CFG_TIME_SCALE:    time_scale_q    <= cfg_data;
				ctso_pkg::CFG_START_LENGTH:  start_length_q  <= cfg_data[14:0];
				ctso_pkg::CFG_STOP_LENGTH:   stop_length_q   <= cfg_data[14:0];
				ctso_pkg::CFG_PORT_ENABLED:  port_enabled_q  <= cfg_data[0];
				ctso_pkg::CFG_INVERT_OUTPUT: invert_output_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			deadline_q   <= '0;
			start_flag_q <= 1'b0;
			stop_flag_q  <= 1'b0;
			relay_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						unique case (in_req) inside
							ctso_pkg::REQ_TICK: begin
								if (off_nonpos)
									state_q <= S_FIN;
								else
									state_q <= S_MUL_O;
							end
							ctso_pkg::REQ_START_DEF, ctso_pkg::REQ_START_EXPL: begin
								// a start while the start flag is still set is ignored
								state_q <= start_flag_q ? S_OUT : S_REQ_MUL;
							end
							ctso_pkg::REQ_STOP_DEF, ctso_pkg::REQ_STOP_EXPL: begin
								state_q <= stop_flag_q ? S_OUT : S_REQ_MUL;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_MUL_O:    state_q <= S_MUL_T;
				S_MUL_T:    state_q <= S_MUL_F;
				S_MUL_F:    state_q <= S_ADD;
				S_ADD:      state_q <= S_DIV_GO;
				S_DIV_GO:   state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_st.done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					relay_q <= fin_relay;
					if (fin_clear) begin
						start_flag_q <= 1'b0;
						stop_flag_q  <= 1'b0;
					end
					state_q <= S_OUT;
				end
				S_REQ_MUL:  state_q <= S_REQ_ADD;
				S_REQ_ADD: begin
					deadline_q   <= now_q + o_q;
					start_flag_q <= is_start_q;
					stop_flag_q  <= !is_start_q;
					relay_q      <= is_start_q;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register valid: a new result wins over draining the old one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q      <= s_axis_tdata[31:0];
			is_start_q <= (in_req == ctso_pkg::REQ_START_DEF) ||
			              (in_req == ctso_pkg::REQ_START_EXPL);
			case (in_req)
				ctso_pkg::REQ_START_DEF: units_q <= start_length_q;
				ctso_pkg::REQ_STOP_DEF:  units_q <= stop_length_q;
				default:                 units_q <= s_axis_tdata[46:32];
			endcase
			// forced-off cycle: result off before inversion
			cyc_on_q <= 1'b0;
		end
		case (state_q) inside
			S_MUL_O, S_REQ_MUL: o_q <= prod;
			S_MUL_T:            t_q <= prod;
			S_MUL_F:            f_q <= prod;
			S_ADD: begin
				o_q <= now_q + o_q;
				f_q <= t_q + f_q;
			end
			S_DIV_WAIT: begin
				if (div_st.done)
					cyc_on_q <= (div_rem < t_q);
			end
			S_OUT: begin
				if (out_load)
					out_data_q <= {stop_flag_q, start_flag_q, relay_q};
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_data_q};

	// checks on the sequencer and timer state
	`CTSO_ASSERT_NOW(a_idle_div_quiet, clk, arst_n, s_axis_tready, !div_st.busy, "divider busy")
	`CTSO_ASSERT_NOW(a_flags_exclusive, clk, arst_n, start_flag_q, !stop_flag_q, "both open")
	`CTSO_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_fire, !s_axis_tready, "ready after accept")
	`CTSO_ASSERT_NOW(a_done_in_wait, clk, arst_n, div_st.done, state_q == S_DIV_WAIT, "stray done")

endmodule
